// File: hdl/amp_pkg.sv
// package for the axis mean pooling block
// holds configuration constants, register indexes, controller states and command/status types
// no dependencies
`default_nettype none

package amp_pkg;

  localparam int MAX_INNER_DEF   = 4096;
  localparam int MAX_AXIS_DEF    = 256;
  localparam int SAMPLE_BITS_DEF = 16;

  localparam int AXIS_REG_W  = 9;
  localparam int INNER_REG_W = 13;
  localparam int POOL_REG_W  = 17;
  localparam int POOL_CNT_W  = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 17;
  localparam int POOL_MAX    = 65536;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_AXIS_LENGTH = 2'd0,
    CFG_INNER_SIZE  = 2'd1,
    CFG_POOL_COUNT  = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ACC,
    S_DIV,
    S_OUT
  } amp_state_e;

  typedef struct packed {
    logic rd_en;
    logic acc;
    logic first;
    logic div_start;
    logic last_elem;
    logic last_blob;
    logic out_load;
  } amp_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic out_free;
  } amp_sts_t;

endpackage

`default_nettype wire

// File: hdl/amp_if.sv
// valid/ready channel interfaces for the axis mean pooling block
// input channel carries one sample, output channel one mean with position and flags
// depends on amp_pkg
`default_nettype none

interface amp_in_if
  import amp_pkg::*;
#(
  parameter int DATA_W = SAMPLE_BITS_DEF
) ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface amp_out_if
  import amp_pkg::*;
#(
  parameter int DATA_W = SAMPLE_BITS_DEF,
  parameter int POS_W  = 12
) ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] mean;
  logic        [POS_W-1:0]  position;
  logic                     last_in_pool;
  logic                     last_in_blob;

  modport source (output valid, output mean, output position, output last_in_pool,
                  output last_in_blob, input ready);
  modport sink   (input valid, input mean, input position, input last_in_pool,
                  input last_in_blob, output ready);
endinterface

`default_nettype wire

// File: hdl/axis_mean_pooling_top.sv
// Mean pooling along one tensor axis. Samples arrive in memory order, pool by pool, each pool
// holding axis_length slices of inner_size elements. An item that is not in the last slice
// of its pool takes a sum memory read, then an add and write back, and gives no result.
// An item in the last slice is then divided by the bit-serial restoring divider, and its
// mean is handed to the output register; the next item is taken while that mean waits for
// the sink. The sum memory is not cleared after reset; the first slice of each pool loads it.
// A config write to any of the three registers restarts the stream at element 0 of slice 0
// of pool 0.
// depends on amp_pkg, amp_if, amp_ctrl, amp_dp
`default_nettype none

module axis_mean_pooling_top
  import amp_pkg::*;
#(
  parameter int MAX_INNER   = MAX_INNER_DEF,
  parameter int MAX_AXIS    = MAX_AXIS_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  amp_in_if.sink                     in_i,
  amp_out_if.source                  out_o
);

  localparam int ElemW = (MAX_INNER > 1) ? $clog2(MAX_INNER) : 1;

  amp_cmd_t              cmd;
  amp_sts_t              sts;
  logic [ElemW-1:0]      elem;
  logic [AXIS_REG_W-1:0] axis;

  amp_ctrl #(
    .MAX_INNER (MAX_INNER),
    .MAX_AXIS  (MAX_AXIS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .elem_o     (elem),
    .axis_o     (axis)
  );

  amp_dp #(
    .MAX_INNER   (MAX_INNER),
    .MAX_AXIS    (MAX_AXIS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .elem_i         (elem),
    .axis_i         (axis),
    .sample_i       (in_i.sample),
    .sts_o          (sts),
    .out_ready_i    (out_o.ready),
    .out_valid_o    (out_o.valid),
    .mean_o         (out_o.mean),
    .pos_o          (out_o.position),
    .last_in_pool_o (out_o.last_in_pool),
    .last_in_blob_o (out_o.last_in_blob)
  );

endmodule

`default_nettype wire

// File: hdl/amp_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module amp_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 4096
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  we_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                      wdata_i,
  input  wire logic                                  re_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// File: hdl/amp_ctrl.sv
// controller for the axis mean pooling block: config registers, stream counters, state machine
// depends on amp_pkg
`default_nettype none

module amp_ctrl
  import amp_pkg::*;
#(
  parameter int MAX_INNER = MAX_INNER_DEF,
  parameter int MAX_AXIS  = MAX_AXIS_DEF
) (
  input  wire logic                                         clk_i,
  input  wire logic                                         rst_ni,
  input  wire logic                                         cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]                         cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0]                        cfg_data_i,
  input  wire logic                                         in_valid_i,
  output logic                                              in_ready_o,
  input  wire amp_sts_t                                     sts_i,
  output amp_cmd_t                                          cmd_o,
  output logic [(MAX_INNER > 1 ? $clog2(MAX_INNER) : 1)-1:0] elem_o,
  output logic [AXIS_REG_W-1:0]                             axis_o
);

  localparam int ElemW  = (MAX_INNER > 1) ? $clog2(MAX_INNER) : 1;
  localparam int SliceW = (MAX_AXIS > 1) ? $clog2(MAX_AXIS) : 1;

  amp_state_e state_q, state_d;

  logic [AXIS_REG_W-1:0]  axis_len_q;
  logic [INNER_REG_W-1:0] inner_size_q;
  logic [POOL_REG_W-1:0]  pool_count_q;

  logic [ElemW-1:0]      elem_q, elem_d;
  logic [SliceW-1:0]     slice_q, slice_d;
  logic [POOL_CNT_W-1:0] pool_q, pool_d;

  logic [AXIS_REG_W-1:0]  axis_eff;
  logic [INNER_REG_W-1:0] inner_eff;
  logic [POOL_REG_W-1:0]  pools_eff;
  logic last_elem, last_slice, last_pool;
  logic in_acc, restart;

  // clamp register values into range
  always_comb begin
    axis_eff = axis_len_q;
    if (axis_len_q == '0) begin
      axis_eff = AXIS_REG_W'(1);
    end else if (32'(axis_len_q) > MAX_AXIS) begin
      axis_eff = AXIS_REG_W'(MAX_AXIS);
    end
    inner_eff = inner_size_q;
    if (inner_size_q == '0) begin
      inner_eff = INNER_REG_W'(1);
    end else if (32'(inner_size_q) > MAX_INNER) begin
      inner_eff = INNER_REG_W'(MAX_INNER);
    end
    pools_eff = pool_count_q;
    if (pool_count_q == '0) begin
      pools_eff = POOL_REG_W'(1);
    end else if (32'(pool_count_q) > POOL_MAX) begin
      pools_eff = POOL_REG_W'(POOL_MAX);
    end
  end

  assign last_elem  = (17'(elem_q) + 17'd1) >= 17'(inner_eff);
  assign last_slice = (17'(slice_q) + 17'd1) >= 17'(axis_eff);
  assign last_pool  = (17'(pool_q) + 17'd1) >= 17'(pools_eff);

  assign in_acc = in_valid_i && in_ready_o;

  // config writes
  always_comb begin
    restart = 1'b0;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_AXIS_LENGTH: restart = 1'b1;
        CFG_INNER_SIZE:  restart = 1'b1;
        CFG_POOL_COUNT:  restart = 1'b1;
        default:         restart = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      axis_len_q   <= AXIS_REG_W'(1);
      inner_size_q <= INNER_REG_W'(1);
      pool_count_q <= POOL_REG_W'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_AXIS_LENGTH: axis_len_q   <= cfg_data_i[AXIS_REG_W-1:0];
        CFG_INNER_SIZE:  inner_size_q <= cfg_data_i[INNER_REG_W-1:0];
        CFG_POOL_COUNT:  pool_count_q <= cfg_data_i[POOL_REG_W-1:0];
        default: ;
      endcase
    end
  end

  // stream position counters, stepped once per item
  always_comb begin
    elem_d  = elem_q;
    slice_d = slice_q;
    pool_d  = pool_q;
    priority if (restart) begin
      elem_d  = '0;
      slice_d = '0;
      pool_d  = '0;
    end else if (state_q == S_ACC) begin
      if (!last_elem) begin
        elem_d = elem_q + ElemW'(1);
      end else begin
        elem_d = '0;
        if (!last_slice) begin
          slice_d = slice_q + SliceW'(1);
        end else begin
          slice_d = '0;
          pool_d  = last_pool ? '0 : pool_q + POOL_CNT_W'(1);
        end
      end
    end else begin
      elem_d  = elem_q;
      slice_d = slice_q;
      pool_d  = pool_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      elem_q  <= '0;
      slice_q <= '0;
      pool_q  <= '0;
    end else begin
      state_q <= state_d;
      elem_q  <= elem_d;
      slice_q <= slice_d;
      pool_q  <= pool_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (in_acc) state_d = S_ACC;
      S_ACC:  state_d = last_slice ? S_DIV : S_IDLE;
      S_DIV:  if (!sts_i.div_busy) state_d = S_OUT;
      S_OUT:  if (sts_i.out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o      = (state_q == S_IDLE);
    cmd_o           = '0;
    cmd_o.rd_en     = in_valid_i && (state_q == S_IDLE);
    cmd_o.acc       = (state_q == S_ACC);
    cmd_o.first     = (slice_q == '0);
    cmd_o.div_start = (state_q == S_ACC) && last_slice;
    cmd_o.last_elem = last_elem;
    cmd_o.last_blob = last_elem && last_pool;
    cmd_o.out_load  = (state_q == S_OUT) && sts_i.out_free;
  end

  assign elem_o = elem_q;
  assign axis_o = axis_eff;

  a_elem_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    17'(elem_q) < 17'(inner_eff)) else $error("element index past slice end");

  a_accept_to_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q == S_ACC) else $error("accepted item not accumulated");

  a_div_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV && !sts_i.div_busy) |=> state_q == S_OUT)
    else $error("finished divide not sent to output");

endmodule

`default_nettype wire

// File: hdl/amp_dp.sv
// datapath for the axis mean pooling block: sum memory, accumulate, bit-serial divider,
// output register; depends on amp_pkg and amp_ram
`default_nettype none

module amp_dp
  import amp_pkg::*;
#(
  parameter int MAX_INNER   = MAX_INNER_DEF,
  parameter int MAX_AXIS    = MAX_AXIS_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  wire logic                                          clk_i,
  input  wire logic                                          rst_ni,
  input  wire amp_cmd_t                                      cmd_i,
  input  wire logic [(MAX_INNER > 1 ? $clog2(MAX_INNER) : 1)-1:0] elem_i,
  input  wire logic [AXIS_REG_W-1:0]                         axis_i,
  input  wire logic signed [SAMPLE_BITS-1:0]                 sample_i,
  output amp_sts_t                                           sts_o,
  input  wire logic                                          out_ready_i,
  output logic                                               out_valid_o,
  output logic signed [SAMPLE_BITS-1:0]                      mean_o,
  output logic [(MAX_INNER > 1 ? $clog2(MAX_INNER) : 1)-1:0] pos_o,
  output logic                                               last_in_pool_o,
  output logic                                               last_in_blob_o
);

  localparam int ElemW = (MAX_INNER > 1) ? $clog2(MAX_INNER) : 1;
  localparam int SumW  = SAMPLE_BITS + $clog2(MAX_AXIS);
  localparam int CntW  = $clog2(SumW + 1);

  logic signed [SAMPLE_BITS-1:0] sample_q;
  logic        [SumW-1:0]        rdata;
  logic signed [SumW-1:0]        sample_ext, sum_d;
  logic        [SumW-1:0]        mag_d;

  logic [AXIS_REG_W-1:0] rem_q, rem_d;
  logic [SumW-1:0]       quo_q, quo_d;
  logic                  neg_q;
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic [AXIS_REG_W:0]   rem_sh;
  logic                  ge;
  logic [SumW-1:0]       quo_signed;

  logic [ElemW-1:0] pos_hold_q;
  logic             lip_hold_q, lib_hold_q;
  logic             out_valid_q;

  amp_ram #(
    .WIDTH (SumW),
    .DEPTH (MAX_INNER)
  ) u_sum_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.acc),
    .waddr_i (elem_i),
    .wdata_i (sum_d),
    .re_i    (cmd_i.rd_en),
    .raddr_i (elem_i),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      sample_q <= sample_i;
    end
  end

  // first slice loads, later slices add
  assign sample_ext = SumW'(sample_q);
  assign sum_d      = cmd_i.first ? sample_ext : $signed(rdata) + sample_ext;
  assign mag_d      = sum_d[SumW-1] ? SumW'(-sum_d) : SumW'(sum_d);

  // restoring divide of the magnitude, one quotient bit per cycle
  assign rem_sh = {rem_q, quo_q[SumW-1]};
  assign ge     = rem_sh >= (AXIS_REG_W + 1)'(axis_i);

  always_comb begin
    rem_d = rem_q;
    quo_d = quo_q;
    cnt_d = cnt_q;
    priority if (cmd_i.div_start) begin
      rem_d = '0;
      quo_d = mag_d;
      cnt_d = CntW'(SumW);
    end else if (cnt_q != '0) begin
      rem_d = ge ? AXIS_REG_W'(rem_sh - (AXIS_REG_W + 1)'(axis_i)) : rem_sh[AXIS_REG_W-1:0];
      quo_d = {quo_q[SumW-2:0], ge};
      cnt_d = cnt_q - CntW'(1);
    end else begin
      rem_d = rem_q;
      quo_d = quo_q;
      cnt_d = cnt_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (cmd_i.div_start) begin
      neg_q <= sum_d[SumW-1];
    end
    if (cmd_i.acc) begin
      pos_hold_q <= elem_i;
      lip_hold_q <= cmd_i.last_elem;
      lib_hold_q <= cmd_i.last_blob;
    end
  end

  assign quo_signed = neg_q ? SumW'(-quo_q) : quo_q;

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      mean_o         <= quo_signed[SAMPLE_BITS-1:0];
      pos_o          <= pos_hold_q;
      last_in_pool_o <= lip_hold_q;
      last_in_blob_o <= lib_hold_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign sts_o.div_busy = (cnt_q != '0);
  assign sts_o.out_free = !out_valid_q || out_ready_i;

endmodule

`default_nettype wire

// File: dv/tb_axis_mean_pooling_top.sv
// testbench for axis_mean_pooling_top: directed table, then random pooling phases under idling
// a built-in average-pooling predictor, or a typed row, queues expected means checked by field
// depends on amp_pkg, amp_if and the axis_mean_pooling_top rtl
`timescale 1ns / 1ps

module tb_axis_mean_pooling_top
  import amp_pkg::*;
();

  localparam int HALF_PERIOD  = 2;
  localparam int DRAIN_CYCLES = 40;
  localparam int HOLD_CYCLES  = 400;
  localparam int WATCHDOG     = 2000;
  localparam int RANDOM_ITEMS = 400;
  localparam int PHASE_CAP    = 400;

  typedef struct packed {
    logic signed [15:0] mean;
    logic [11:0]        position;
    logic               last_in_pool;
    logic               last_in_blob;
  } mean_res_t;

  typedef enum bit {ROW_CFG, ROW_ITEM} row_kind_e;

  typedef struct packed {
    row_kind_e          kind;
    logic [8:0]         axis;
    logic [12:0]        inner;
    logic [16:0]        pool;
    logic signed [15:0] sample;
    bit                 typed;
    mean_res_t          want;
  } row_t;

  typedef struct {
    logic [8:0]  axis;
    logic [12:0] inner;
    logic [16:0] pool;
    int          items;
    bit          fill;
  } phase_t;

  // typed means only where the value is obvious
  localparam row_t DIRECTED [27] = '{
    '{ROW_ITEM, 9'd0, 13'd0, 17'd0, 16'sh7fff, 1'b1, '{16'sh7fff, 12'd0, 1'b1, 1'b1}},
    '{ROW_ITEM, 9'd0, 13'd0, 17'd0, 16'sh8000, 1'b1, '{16'sh8000, 12'd0, 1'b1, 1'b1}},
    '{ROW_ITEM, 9'd0, 13'd0, 17'd0, 16'sh0000, 1'b1, '{16'sh0000, 12'd0, 1'b1, 1'b1}},
    '{ROW_ITEM, 9'd0, 13'd0, 17'd0, 16'sh0001, 1'b1, '{16'sh0001, 12'd0, 1'b1, 1'b1}},
    '{ROW_CFG,  9'd0, 13'd3, 17'd2, 16'sh0000, 1'b0, '0},
    '{ROW_ITEM, 9'd0, 13'd0, 17'd0, 16'shffff, 1'b1, '{16'shffff, 12'd0, 1'b0, 1'b0}},
    '{ROW_ITEM, 9'd0, 13'd0, 17'd0, 16'sh7fff, 1'b1, '{16'sh7fff, 12'd1, 1'b0, 1'b0}},
    '{ROW_ITEM, 9'd0, 13'd0, 17'd0, 16'sh8000, 1'b1, '{16'sh8000, 12'd2, 1'b1, 1'b0}},
    '{ROW_ITEM, 9'd0, 13'd0, 17'd0, 16'sh0002, 1'b1, '{16'sh0002, 12'd0, 1'b0, 1'b0}},
    '{ROW_ITEM, 9'd0, 13'd0, 17'd0, 16'shfffd, 1'b1, '{16'shfffd, 12'd1, 1'b0, 1'b0}},
    '{ROW_ITEM, 9'd0, 13'd0, 17'd0, 16'sh0064, 1'b1, '{16'sh0064, 12'd2, 1'b1, 1'b1}},
    '{ROW_CFG,  9'd2, 13'd1, 17'd1, 16'sh0000, 1'b0, '0},
    '{ROW_ITEM, 9'd0, 13'd0, 17'd0, 16'sh0003, 1'b0, '0},
    '{ROW_ITEM, 9'd0, 13'd0, 17'd0, 16'shfffc, 1'b1, '{16'sh0000, 12'd0, 1'b1, 1'b1}},
    '{ROW_ITEM, 9'd0, 13'd0, 17'd0, 16'sh7fff, 1'b0, '0},
    '{ROW_ITEM, 9'd0, 13'd0, 17'd0, 16'sh7fff, 1'b1, '{16'sh7fff, 12'd0, 1'b1, 1'b1}},
    '{ROW_ITEM, 9'd0, 13'd0, 17'd0, 16'sh8000, 1'b0, '0},
    '{ROW_ITEM, 9'd0, 13'd0, 17'd0, 16'sh8000, 1'b1, '{16'sh8000, 12'd0, 1'b1, 1'b1}},
    '{ROW_ITEM, 9'd0, 13'd0, 17'd0, 16'shfffd, 1'b0, '0},
    '{ROW_ITEM, 9'd0, 13'd0, 17'd0, 16'sh0000, 1'b1, '{16'shffff, 12'd0, 1'b1, 1'b1}},
    '{ROW_CFG,  9'd3, 13'd0, 17'd0, 16'sh0000, 1'b0, '0},
    '{ROW_ITEM, 9'd0, 13'd0, 17'd0, 16'sh0001, 1'b0, '0},
    '{ROW_ITEM, 9'd0, 13'd0, 17'd0, 16'sh0001, 1'b0, '0},
    '{ROW_ITEM, 9'd0, 13'd0, 17'd0, 16'shfffe, 1'b1, '{16'sh0000, 12'd0, 1'b1, 1'b1}},
    '{ROW_ITEM, 9'd0, 13'd0, 17'd0, 16'sh8000, 1'b0, '0},
    '{ROW_ITEM, 9'd0, 13'd0, 17'd0, 16'sh8000, 1'b0, '0},
    '{ROW_ITEM, 9'd0, 13'd0, 17'd0, 16'sh8001, 1'b1, '{16'sh8001, 12'd0, 1'b1, 1'b1}}
  };

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we;
  cfg_idx_e              cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  amp_in_if  u_in ();
  amp_out_if u_out ();

  axis_mean_pooling_top u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (u_in),
    .out_o      (u_out)
  );

  always #(HALF_PERIOD) clk_i = ~clk_i;

  // predictor state
  logic [8:0]  axis_reg  = 9'd1;
  logic [12:0] inner_reg = 13'd1;
  logic [16:0] pool_reg  = 17'd1;
  int          sum_mem [MAX_INNER_DEF];
  int          elem_cnt  = 0;
  int          slice_cnt = 0;
  int          pool_cnt  = 0;

  mean_res_t   pending_means [$];
  int          err_cnt        = 0;
  int          send_idle_pct  = 0;
  int          recv_stall_pct = 0;
  int          hold_ask       = 0;
  int          hold_seen      = 0;
  int          hold_left      = 0;
  int          idle_cycles    = 0;

  function automatic int clamp_reg(input int v, input int hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic bit avg_sample(input logic signed [15:0] s, output mean_res_t r);
    int axis_e, inner_e, pool_e, e;
    bit last_elem, last_slice, last_pool;
    axis_e  = clamp_reg(int'(axis_reg), MAX_AXIS_DEF);
    inner_e = clamp_reg(int'(inner_reg), MAX_INNER_DEF);
    pool_e  = clamp_reg(int'(pool_reg), POOL_MAX);
    e = (elem_cnt >= inner_e) ? inner_e - 1 : elem_cnt;
    last_elem  = (e + 1 >= inner_e);
    last_slice = (slice_cnt + 1 >= axis_e);
    last_pool  = (pool_cnt + 1 >= pool_e);
    if (slice_cnt == 0) sum_mem[e] = int'(s);
    else sum_mem[e] = sum_mem[e] + int'(s);
    r = '0;
    if (last_slice) begin
      r.mean         = 16'(sum_mem[e] / axis_e);
      r.position     = 12'(e);
      r.last_in_pool = last_elem;
      r.last_in_blob = last_elem && last_pool;
    end
    if (!last_elem) begin
      elem_cnt = e + 1;
    end else begin
      elem_cnt = 0;
      if (!last_slice) begin
        slice_cnt++;
      end else begin
        slice_cnt = 0;
        pool_cnt  = last_pool ? 0 : pool_cnt + 1;
      end
    end
    return last_slice;
  endfunction

  task automatic configure(input logic [8:0] a, input logic [12:0] n, input logic [16:0] p);
    u_in.valid <= 1'b0;
    while (pending_means.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_AXIS_LENGTH;
    cfg_data <= CFG_DATA_W'(a);
    @(posedge clk_i);
    cfg_idx  <= CFG_INNER_SIZE;
    cfg_data <= CFG_DATA_W'(n);
    @(posedge clk_i);
    cfg_idx  <= CFG_POOL_COUNT;
    cfg_data <= p;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    axis_reg  = a;
    inner_reg = n;
    pool_reg  = p;
    elem_cnt  = 0;
    slice_cnt = 0;
    pool_cnt  = 0;
  endtask

  task automatic send_sample(input logic signed [15:0] s, input bit typed, input mean_res_t want);
    mean_res_t r;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      u_in.valid <= 1'b0;
      @(posedge clk_i);
    end
    u_in.valid  <= 1'b1;
    u_in.sample <= s;
    @(posedge clk_i);
    while (!u_in.ready) @(posedge clk_i);
    if (avg_sample(s, r)) pending_means.push_back(typed ? want : r);
  endtask

  always @(posedge clk_i) begin : mean_sink
    mean_res_t got, want;
    if (rst_ni && u_out.valid && u_out.ready) begin
      got.mean         = u_out.mean;
      got.position     = u_out.position;
      got.last_in_pool = u_out.last_in_pool;
      got.last_in_blob = u_out.last_in_blob;
      if (pending_means.size() == 0) begin
        $error("unexpected item: mean %0d position %0d", got.mean, got.position);
        err_cnt++;
      end else begin
        want = pending_means.pop_front();
        if (got.mean !== want.mean) begin
          $error("mean: expected %0d, got %0d", want.mean, got.mean);
          err_cnt++;
        end
        if (got.position !== want.position) begin
          $error("position: expected %0d, got %0d", want.position, got.position);
          err_cnt++;
        end
        if (got.last_in_pool !== want.last_in_pool) begin
          $error("last_in_pool: expected %0b, got %0b", want.last_in_pool, got.last_in_pool);
          err_cnt++;
        end
        if (got.last_in_blob !== want.last_in_blob) begin
          $error("last_in_blob: expected %0b, got %0b", want.last_in_blob, got.last_in_blob);
          err_cnt++;
        end
      end
    end
    if (hold_left > 0) begin
      hold_left--;
      u_out.ready <= 1'b0;
    end else if (hold_seen != hold_ask) begin
      hold_seen = hold_ask;
      hold_left = HOLD_CYCLES;
      u_out.ready <= 1'b0;
    end else begin
      u_out.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((u_in.valid && u_in.ready) || (u_out.valid && u_out.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    phase_t             phases [$];
    phase_t             ph;
    int                 rand_items;
    int                 axis_e, inner_e, pool_e;
    longint             blob;
    logic signed [15:0] s;
    rst_ni      <= 1'b0;
    cfg_we      <= 1'b0;
    cfg_idx     <= CFG_AXIS_LENGTH;
    cfg_data    <= '0;
    u_in.valid  <= 1'b0;
    u_in.sample <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DIRECTED[i]) begin
      if (DIRECTED[i].kind == ROW_CFG) begin
        configure(DIRECTED[i].axis, DIRECTED[i].inner, DIRECTED[i].pool);
      end else begin
        send_sample(DIRECTED[i].sample, DIRECTED[i].typed, DIRECTED[i].want);
      end
    end

    // register extremes first, then random shapes
    phases.push_back('{9'd1, 13'h1000, 17'd1, 400, 1'b0});
    phases.push_back('{9'h100, 13'd1, 17'd2, 512, 1'b1});
    phases.push_back('{9'h1ff, 13'd1, 17'd0, 260, 1'b0});
    phases.push_back('{9'd0, 13'h1fff, 17'd1, 200, 1'b0});
    phases.push_back('{9'd3, 13'd2, 17'h1ffff, 60, 1'b0});
    phases.push_back('{9'd1, 13'd1, 17'h10000, 40, 1'b0});
    rand_items = 0;
    while (rand_items < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0:       ph.axis = 9'd0;
        1:       ph.axis = 9'($urandom_range(257, 511));
        default: ph.axis = 9'($urandom_range(1, 8));
      endcase
      if (ph.axis > 9'd8) begin
        ph.inner = 13'($urandom_range(0, 2));
      end else begin
        case ($urandom_range(0, 9))
          0:       ph.inner = 13'd0;
          1:       ph.inner = 13'($urandom_range(4097, 8191));
          default: ph.inner = 13'($urandom_range(1, 24));
        endcase
      end
      case ($urandom_range(0, 9))
        0:       ph.pool = 17'd0;
        1:       ph.pool = 17'($urandom_range(65537, 131071));
        default: ph.pool = 17'($urandom_range(1, 4));
      endcase
      blob = longint'(clamp_reg(int'(ph.axis), MAX_AXIS_DEF))
           * clamp_reg(int'(ph.inner), MAX_INNER_DEF)
           * clamp_reg(int'(ph.pool), POOL_MAX) * $urandom_range(1, 2);
      ph.items = (blob > PHASE_CAP) ? PHASE_CAP : int'(blob);
      if ($urandom_range(0, 4) == 0) ph.items = $urandom_range(1, ph.items);
      ph.fill = 1'b0;
      phases.push_back(ph);
      rand_items += ph.items;
    end

    foreach (phases[p]) begin
      ph = phases[p];
      configure(ph.axis, ph.inner, ph.pool);
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 69; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 69; end
        default: begin send_idle_pct = 26; recv_stall_pct = 26; end
      endcase
      // long output hold-off so the input side backs up
      if (p == 0) hold_ask++;
      axis_e  = clamp_reg(int'(ph.axis), MAX_AXIS_DEF);
      inner_e = clamp_reg(int'(ph.inner), MAX_INNER_DEF);
      pool_e  = clamp_reg(int'(ph.pool), POOL_MAX);
      for (int k = 0; k < ph.items; k++) begin
        if (ph.fill) begin
          s = ((k / (axis_e * inner_e)) % 2 != 0) ? 16'sh7fff : 16'sh8000;
        end else begin
          case ($urandom_range(0, 15))
            0:       s = 16'sh7fff;
            1:       s = 16'sh8000;
            2:       s = 16'sh0000;
            3:       s = 16'shffff;
            default: s = 16'($urandom);
          endcase
        end
        send_sample(s, 1'b0, '0);
      end
    end

    u_in.valid <= 1'b0;
    while (pending_means.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (err_cnt == 0 && pending_means.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
